/* hdl/gbs_pkg.sv */
// Package for the greedy box suppressor.
// Holds the sequencer state type, field widths and reset constants.
// No dependencies.
package gbs_pkg;

    localparam int FIELD_W        = 16;
    localparam int NUM_W          = 10;
    localparam int THR_W          = 16;
    localparam int FRAC_SHIFT     = 16;
    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    localparam logic [NUM_W-1:0] COUNTER_MAX = 10'd1023;
    localparam logic [THR_W-1:0] THR_RESET   = 16'd29491;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

/* hdl/gbs_store.sv */
// Kept box store: one write port, one registered read port.
// Read valid is registered: it follows the read enable in the next cycle.
// Depends on nothing.
module gbs_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 96
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    output logic              o_rd_valid
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_en;
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

/* hdl/gbs_iou_unit.sv */
// Pipelined overlap test: one kept box per cycle against the current box.
// Flags a hit when inter * 65536 > threshold * union. Uses gbs_pkg.
module gbs_iou_unit #(
    parameter int CW = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [CW-1:0]                        i_kx1,
    input  logic [CW-1:0]                        i_ky1,
    input  logic [CW-1:0]                        i_kx2,
    input  logic [CW-1:0]                        i_ky2,
    input  logic [2*CW-1:0]                      i_karea,
    input  logic [CW-1:0]                        i_x1,
    input  logic [CW-1:0]                        i_y1,
    input  logic [CW-1:0]                        i_x2,
    input  logic [CW-1:0]                        i_y2,
    input  logic [2*CW-1:0]                      i_area,
    input  logic [gbs_pkg::THR_W-1:0]            i_thr,
    output logic                                 o_hit,
    output logic                                 o_busy
);

    localparam int A_W = 2 * CW;
    localparam int U_W = A_W + 1;
    localparam int C_W = U_W + gbs_pkg::THR_W;

    logic [CW-1:0]  w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    logic [CW-1:0]  w_iw, w_ih;

    logic           r_v1, r_v2, r_v3, r_v4;
    logic [CW-1:0]  r_iw, r_ih;
    logic [A_W-1:0] r_ka1, r_ka2, r_inter;
    logic [U_W-1:0] r_uni;
    logic [C_W-1:0] r_lhs3, r_lhs4, r_rhs;

    always_comb begin
        w_lo_x = (i_x1 > i_kx1) ? i_x1 : i_kx1;
        w_hi_x = (i_x2 < i_kx2) ? i_x2 : i_kx2;
        w_lo_y = (i_y1 > i_ky1) ? i_y1 : i_ky1;
        w_hi_y = (i_y2 < i_ky2) ? i_y2 : i_ky2;
        w_iw   = (w_hi_x > w_lo_x) ? (w_hi_x - w_lo_x) : '0;
        w_ih   = (w_hi_y > w_lo_y) ? (w_hi_y - w_lo_y) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iw    <= w_iw;
        r_ih    <= w_ih;
        r_ka1   <= i_karea;
        r_inter <= A_W'(r_iw) * A_W'(r_ih);
        r_ka2   <= r_ka1;
        r_uni   <= U_W'(i_area) + U_W'(r_ka2) - U_W'(r_inter);
        r_lhs3  <= {1'b0, r_inter, {gbs_pkg::FRAC_SHIFT{1'b0}}};
        r_lhs4  <= r_lhs3;
        r_rhs   <= C_W'(i_thr) * C_W'(r_uni);
    end

    assign o_hit  = r_v4 && (r_lhs4 > r_rhs);
    assign o_busy = r_v1 || r_v2 || r_v3 || r_v4;

endmodule

/* hdl/greedy_box_suppressor.sv */
// Greedy box suppressor top level: sequencer, counters, output register.
// Uses gbs_pkg, gbs_store and gbs_iou_unit.
//
// Usage: boxes come in on i_valid/o_stall, sorted by descending score, with
// i_frame_start set on the first box of a frame. One result per box leaves on
// o_valid/i_stall: its number in the frame, whether it was kept, and whether
// it survived but found the store full. i_cfg_wr_en/i_cfg_wr_data set the
// overlap threshold (fraction of 65536); write it only while idle.
// Timing: a box is compared with the N boxes kept so far, one per cycle,
// through a four stage overlap pipeline fed by the registered store read.
// N is at most MAX_KEPT. o_stall stays high from the transfer of a box until
// its result is in the output register, so no new box is taken while one is
// in work; the next box is taken as soon as the result sits in the output
// register.
// Reset: synchronous, clears the kept count, box counter, result valid and
// restores the threshold; store contents need no clearing.
// A stalled result holds; a finished box waits for the output register
// to free up before its result and store write go out.
module greedy_box_suppressor #(
    parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEF,
    parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [gbs_pkg::THR_W-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [gbs_pkg::FIELD_W-1:0]   i_left_edge,
    input  logic [gbs_pkg::FIELD_W-1:0]   i_top_edge,
    input  logic [gbs_pkg::FIELD_W-1:0]   i_right_edge,
    input  logic [gbs_pkg::FIELD_W-1:0]   i_bottom_edge,
    input  logic                          i_frame_start,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gbs_pkg::NUM_W-1:0]     o_box_number,
    output logic                          o_kept,
    output logic                          o_store_full
);

    localparam int CW     = (COORD_BITS < gbs_pkg::FIELD_W) ? COORD_BITS : gbs_pkg::FIELD_W;
    localparam int A_W    = 2 * CW;
    localparam int ENT_W  = 4 * CW + A_W;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam logic [CNT_W-1:0] KEPT_LIMIT = CNT_W'(MAX_KEPT);

    gbs_pkg::t_state r_state, n_state;

    logic [gbs_pkg::THR_W-1:0] r_thr;
    logic [CW-1:0]             r_x1, r_y1, r_x2, r_y2;
    logic [A_W-1:0]            r_area;
    logic [CNT_W-1:0]          r_total, r_idx;
    logic [gbs_pkg::NUM_W-1:0] r_count, r_num, w_base;
    logic                      r_supp;
    logic                      r_ovalid, r_okept, r_ofull;
    logic [gbs_pkg::NUM_W-1:0] r_onum;

    logic w_accept, w_scan_end, w_out_free, w_rd_en, w_finish, w_store;
    logic w_room;
    logic [CW-1:0] w_sx, w_sy;

    logic [ENT_W-1:0] w_rd_data, w_wr_data;
    logic             w_rd_valid, w_hit, w_busy;

    assign w_accept   = i_valid && !o_stall;
    assign w_scan_end = (r_idx == r_total);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_room     = (r_total < KEPT_LIMIT);
    assign w_store    = w_finish && !r_supp && w_room;
    assign w_base     = i_frame_start ? '0 : r_count;
    assign w_sx       = (r_x2 > r_x1) ? (r_x2 - r_x1) : '0;
    assign w_sy       = (r_y2 > r_y1) ? (r_y2 - r_y1) : '0;
    assign w_wr_data  = {r_x1, r_y1, r_x2, r_y2, r_area};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbs_pkg::S_IDLE:  if (i_valid) n_state = gbs_pkg::S_AREA;
            gbs_pkg::S_AREA:  n_state = gbs_pkg::S_SCAN;
            gbs_pkg::S_SCAN:  if (w_scan_end) n_state = gbs_pkg::S_DRAIN;
            gbs_pkg::S_DRAIN: if (!w_rd_valid && !w_busy) n_state = gbs_pkg::S_DONE;
            gbs_pkg::S_DONE:  if (w_out_free) n_state = gbs_pkg::S_IDLE;
            default:          n_state = gbs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = 1'b1;
        w_rd_en  = 1'b0;
        w_finish = 1'b0;
        unique case (r_state)
            gbs_pkg::S_IDLE: o_stall  = 1'b0;
            gbs_pkg::S_SCAN: w_rd_en  = !w_scan_end;
            gbs_pkg::S_DONE: w_finish = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gbs_pkg::S_IDLE;
            r_thr    <= gbs_pkg::THR_RESET;
            r_total  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_count <= (w_base < gbs_pkg::COUNTER_MAX) ? w_base + 1'b1 : w_base;
                if (i_frame_start) begin
                    r_total <= '0;
                end
            end else if (w_store) begin
                r_total <= r_total + 1'b1;
            end
            if (w_finish) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x1   <= i_left_edge[CW-1:0];
            r_y1   <= i_top_edge[CW-1:0];
            r_x2   <= i_right_edge[CW-1:0];
            r_y2   <= i_bottom_edge[CW-1:0];
            r_num  <= w_base;
            r_idx  <= '0;
            r_supp <= 1'b0;
        end else begin
            if (w_rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_hit) begin
                r_supp <= 1'b1;
            end
        end
        if (r_state == gbs_pkg::S_AREA) begin
            r_area <= A_W'(w_sx) * A_W'(w_sy);
        end
        if (w_finish) begin
            r_onum  <= r_num;
            r_okept <= !r_supp && w_room;
            r_ofull <= !r_supp && !w_room;
        end
    end

    gbs_store #(
        .DEPTH  (MAX_KEPT),
        .ADDR_W (ADDR_W),
        .DATA_W (ENT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_store),
        .i_wr_addr  (r_total[ADDR_W-1:0]),
        .i_wr_data  (w_wr_data),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (r_idx[ADDR_W-1:0]),
        .o_rd_data  (w_rd_data),
        .o_rd_valid (w_rd_valid)
    );

    gbs_iou_unit #(
        .CW (CW)
    ) u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rd_valid),
        .i_kx1   (w_rd_data[A_W+4*CW-1 -: CW]),
        .i_ky1   (w_rd_data[A_W+3*CW-1 -: CW]),
        .i_kx2   (w_rd_data[A_W+2*CW-1 -: CW]),
        .i_ky2   (w_rd_data[A_W+CW-1 -: CW]),
        .i_karea (w_rd_data[A_W-1:0]),
        .i_x1    (r_x1),
        .i_y1    (r_y1),
        .i_x2    (r_x2),
        .i_y2    (r_y2),
        .i_area  (r_area),
        .i_thr   (r_thr),
        .o_hit   (w_hit),
        .o_busy  (w_busy)
    );

    assign o_valid      = r_ovalid;
    assign o_box_number = r_onum;
    assign o_kept       = r_okept;
    assign o_store_full = r_ofull;

endmodule
